// ===== src/three_wire_rtc_serial_master_defines.svh =====
`ifndef THREE_WIRE_RTC_SERIAL_MASTER_DEFINES_SVH
`define THREE_WIRE_RTC_SERIAL_MASTER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RTC3W_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RTC3W_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rtc3w_pkg.sv =====
package rtc3w_pkg;

    localparam int BURST_BYTES = 8;
    localparam int BUF_DEPTH   = 8;
    localparam int SLOT_W      = 3;
    localparam int CNT_RAW_W   = $clog2(BURST_BYTES + 2);
    localparam int BYTE_CNT_W  = (CNT_RAW_W > SLOT_W) ? CNT_RAW_W : SLOT_W;
    localparam int DEC_ZERO_POS = 7;

    localparam logic [7:0] CMD_WRITE  = 8'h80;
    localparam logic [7:0] CMD_READ   = 8'h81;
    localparam logic [7:0] CMD_BWRITE = 8'hBE;
    localparam logic [7:0] CMD_BREAD  = 8'hBF;

    typedef enum logic [2:0] {
        FUNC_TICK   = 3'd0,
        FUNC_SWRITE = 3'd1,
        FUNC_SREAD  = 3'd2,
        FUNC_BWRITE = 3'd3,
        FUNC_BREAD  = 3'd4,
        FUNC_LOAD   = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        KIND_SWRITE = 2'd0,
        KIND_SREAD  = 2'd1,
        KIND_BWRITE = 2'd2,
        KIND_BREAD  = 2'd3
    } kind_t;

    typedef struct packed {
        logic       io_sample;
        logic       decimal_mode;
        logic [7:0] write_value;
        logic [2:0] reg_index;
        logic [2:0] func;
    } item_t;

    typedef struct packed {
        logic       done_res;
        logic       busy_res;
        logic       read_valid;
        logic [2:0] read_slot;
        logic [7:0] read_value;
        logic       io_drive_level;
        logic       sclk_level;
        logic       ce_level;
    } result_t;

    function automatic logic [7:0] to_bcd(input logic [7:0] v);
        logic [6:0]  sat;
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  tens_x10;
        logic [6:0]  ones;
        sat      = (v > 8'd99) ? 7'd99 : v[6:0];
        prod     = 15'(sat) * 15'd205;
        tens     = prod[14:11];
        tens_x10 = {tens, 3'b000} + 7'({tens, 1'b0});
        ones     = sat - tens_x10;
        return {tens, ones[3:0]};
    endfunction

    function automatic logic [7:0] from_bcd(input logic [7:0] v);
        logic [7:0] hi;
        hi = {4'd0, v[7:4]};
        return (hi << 3) + (hi << 1) + {4'd0, v[3:0]};
    endfunction

endpackage

// ===== src/rtc3w_engine.sv =====
`include "three_wire_rtc_serial_master_defines.svh"

module rtc3w_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  rtc3w_pkg::item_t  item,
    output rtc3w_pkg::result_t res
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SEND = 2'd1,
        PH_RECV = 2'd2,
        PH_END  = 2'd3
    } phase_t;

    localparam int CW = rtc3w_pkg::BYTE_CNT_W;

    phase_t                phase_reg, phase_next;
    rtc3w_pkg::kind_t      kind_reg, kind_next;
    logic [2:0]            bit_count_reg, bit_count_next;
    logic                  half_bit_reg, half_bit_next;
    logic [CW-1:0]         byte_count_reg, byte_count_next;
    logic [7:0]            shift_reg, shift_next;
    logic                  dec_reg, dec_next;
    logic                  ce_reg, ce_next;
    logic                  sclk_reg, sclk_next;
    logic                  io_reg, io_next;
    logic [7:0]            pend_reg, pend_next;
    logic [7:0]            buf_mem [rtc3w_pkg::BUF_DEPTH];

    logic [CW-1:0]         bc_inc;
    logic [CW-1:0]         total;
    logic                  last_byte;
    logic                  is_write;
    logic [7:0]            buf_word;
    logic [7:0]            out_byte;
    logic [7:0]            shifted;
    logic [7:0]            start_wv;

    always_comb begin
        bc_inc    = byte_count_reg + CW'(1);
        total     = (kind_reg == rtc3w_pkg::KIND_SWRITE || kind_reg == rtc3w_pkg::KIND_SREAD)
                    ? CW'(1) : CW'(rtc3w_pkg::BURST_BYTES);
        last_byte = bc_inc > total;
        is_write  = (kind_reg == rtc3w_pkg::KIND_SWRITE || kind_reg == rtc3w_pkg::KIND_BWRITE);
        buf_word  = buf_mem[byte_count_reg[rtc3w_pkg::SLOT_W-1:0]];
        if (kind_reg == rtc3w_pkg::KIND_SWRITE) begin
            out_byte = pend_reg;
        end else if (dec_reg) begin
            out_byte = (32'(byte_count_reg) == 32'(rtc3w_pkg::DEC_ZERO_POS))
                       ? 8'd0 : rtc3w_pkg::to_bcd(buf_word);
        end else begin
            out_byte = buf_word;
        end
        shifted  = shift_reg | (8'(item.io_sample) << bit_count_reg);
        start_wv = item.decimal_mode ? rtc3w_pkg::to_bcd(item.write_value) : item.write_value;
    end

    always_comb begin
        phase_next      = phase_reg;
        kind_next       = kind_reg;
        bit_count_next  = bit_count_reg;
        half_bit_next   = half_bit_reg;
        byte_count_next = byte_count_reg;
        shift_next      = shift_reg;
        dec_next        = dec_reg;
        ce_next         = ce_reg;
        sclk_next       = sclk_reg;
        io_next         = io_reg;
        pend_next       = pend_reg;
        res             = '0;

        case (item.func)
            rtc3w_pkg::FUNC_SWRITE, rtc3w_pkg::FUNC_SREAD,
            rtc3w_pkg::FUNC_BWRITE, rtc3w_pkg::FUNC_BREAD: begin
                if (phase_reg == PH_IDLE) begin
                    kind_next       = rtc3w_pkg::kind_t'(2'(item.func - 3'd1));
                    dec_next        = item.decimal_mode;
                    pend_next       = start_wv;
                    case (item.func)
                        rtc3w_pkg::FUNC_SWRITE:
                            shift_next = {4'd0, item.reg_index, 1'b0} | rtc3w_pkg::CMD_WRITE;
                        rtc3w_pkg::FUNC_SREAD:
                            shift_next = {4'd0, item.reg_index, 1'b0} | rtc3w_pkg::CMD_READ;
                        rtc3w_pkg::FUNC_BWRITE:
                            shift_next = rtc3w_pkg::CMD_BWRITE;
                        default:
                            shift_next = rtc3w_pkg::CMD_BREAD;
                    endcase
                    bit_count_next  = 3'd0;
                    half_bit_next   = 1'b0;
                    byte_count_next = '0;
                    phase_next      = PH_SEND;
                    ce_next         = 1'b1;
                    sclk_next       = 1'b0;
                end
            end
            rtc3w_pkg::FUNC_TICK: begin
                case (phase_reg)
                    PH_SEND: begin
                        if (!half_bit_reg) begin
                            io_next       = shift_reg[bit_count_reg];
                            sclk_next     = 1'b0;
                            half_bit_next = 1'b1;
                        end else begin
                            sclk_next     = 1'b1;
                            half_bit_next = 1'b0;
                            if (bit_count_reg == 3'd7) begin
                                byte_count_next = bc_inc;
                                bit_count_next  = 3'd0;
                                if (last_byte) begin
                                    phase_next = PH_END;
                                end else if (is_write) begin
                                    shift_next = out_byte;
                                    phase_next = PH_SEND;
                                end else begin
                                    shift_next = 8'd0;
                                    phase_next = PH_RECV;
                                end
                            end else begin
                                bit_count_next = bit_count_reg + 3'd1;
                            end
                        end
                    end
                    PH_RECV: begin
                        if (!half_bit_reg) begin
                            sclk_next     = 1'b1;
                            half_bit_next = 1'b1;
                        end else begin
                            sclk_next     = 1'b0;
                            half_bit_next = 1'b0;
                            shift_next    = shifted;
                            if (bit_count_reg == 3'd7) begin
                                res.read_value  = dec_reg ? rtc3w_pkg::from_bcd(shifted) : shifted;
                                res.read_slot   = 3'(byte_count_reg - CW'(1));
                                res.read_valid  = 1'b1;
                                byte_count_next = bc_inc;
                                bit_count_next  = 3'd0;
                                if (last_byte) begin
                                    phase_next = PH_END;
                                end else begin
                                    shift_next = 8'd0;
                                    phase_next = PH_RECV;
                                end
                            end else begin
                                bit_count_next = bit_count_reg + 3'd1;
                            end
                        end
                    end
                    PH_END: begin
                        ce_next      = 1'b0;
                        sclk_next    = 1'b0;
                        io_next      = 1'b0;
                        phase_next   = PH_IDLE;
                        res.done_res = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        res.ce_level       = ce_next;
        res.sclk_level     = sclk_next;
        res.io_drive_level = io_next;
        res.busy_res       = (phase_next != PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            kind_reg       <= rtc3w_pkg::KIND_SWRITE;
            bit_count_reg  <= '0;
            half_bit_reg   <= 1'b0;
            byte_count_reg <= '0;
            shift_reg      <= '0;
            dec_reg        <= 1'b0;
            ce_reg         <= 1'b0;
            sclk_reg       <= 1'b0;
            io_reg         <= 1'b0;
            pend_reg       <= '0;
        end else if (step) begin
            phase_reg      <= phase_next;
            kind_reg       <= kind_next;
            bit_count_reg  <= bit_count_next;
            half_bit_reg   <= half_bit_next;
            byte_count_reg <= byte_count_next;
            shift_reg      <= shift_next;
            dec_reg        <= dec_next;
            ce_reg         <= ce_next;
            sclk_reg       <= sclk_next;
            io_reg         <= io_next;
            pend_reg       <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && item.func == rtc3w_pkg::FUNC_LOAD) begin
            buf_mem[item.reg_index] <= item.write_value;
        end
    end

    `RTC3W_ASSERT_SAME(a_idle_pins_low, phase_reg == PH_IDLE, !ce_reg && !sclk_reg,
        "bus idle with CE or SCLK high")
    `RTC3W_ASSERT_NEXT(a_hold_without_step, !step,
        $stable(phase_reg) && $stable(shift_reg) && $stable(bit_count_reg),
        "engine state moved without a word")
    `RTC3W_ASSERT_SAME(a_read_in_recv, res.read_valid,
        phase_reg == PH_RECV && half_bit_reg && bit_count_reg == 3'd7,
        "byte completed outside receive phase")
    `RTC3W_ASSERT_NEXT(a_idle_tick_quiet,
        step && phase_reg == PH_IDLE && item.func == rtc3w_pkg::FUNC_TICK,
        phase_reg == PH_IDLE && $stable({ce_reg, sclk_reg, io_reg}),
        "tick while idle changed the bus")

endmodule

// ===== src/three_wire_rtc_serial_master.sv =====
// Pin-level master for a three-wire RTC bus. Each input word is either a tick that moves the
// bus by one half-bit, a transfer start (single or burst, write or read), a burst buffer load
// or one of the two spare codes, which change nothing; each word yields exactly one result
// word carrying the CE/SCLK/IO levels, any byte completed on that tick, and busy/done flags.
// A word passes through an input register and then a result register before its result is on
// m_tdata. One word is taken every cycle for as long as m_tready stays high; with m_tready low
// the block holds two words and then drops s_tready.
module three_wire_rtc_serial_master (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // reg_index[2:0], write_value[10:3], decimal_mode[11],
                                  // io_sample[12], zero[15:13]
    input  logic [2:0]  s_tuser,  // func[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // ce_level[0], sclk_level[1], io_drive_level[2],
                                  // read_value[10:3], read_slot[13:11], read_valid[14],
                                  // busy_res[15], done_res[16], zero[23:17]
);

    logic               in_valid_reg, in_valid_next;
    rtc3w_pkg::item_t   in_item_reg;
    logic               out_valid_reg, out_valid_next;
    rtc3w_pkg::result_t out_res_reg;
    rtc3w_pkg::result_t res;
    logic               advance;
    logic               step;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = advance && in_valid_reg;
    assign s_tready = advance || !in_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_res_reg};

    always_comb begin
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    rtc3w_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= {s_tdata[12:0], s_tuser};
        end
        if (step) begin
            out_res_reg <= res;
        end
    end

endmodule

// ===== tb/tb_rtc3w_checker.sv =====
`timescale 1ns / 100ps

module tb_rtc3w_checker
    import rtc3w_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    output int          fail_count,
    output int          pending
);

    typedef enum logic [1:0] {
        BUS_IDLE,
        BUS_SEND,
        BUS_RECV,
        BUS_STOP
    } bus_phase_t;

    bus_phase_t bus_phase   = BUS_IDLE;
    kind_t      xfer_kind   = KIND_SWRITE;
    logic [2:0] bit_idx     = '0;
    logic       second_half = 1'b0;
    logic [BYTE_CNT_W-1:0] byte_idx = '0;
    logic [7:0] shifter     = '0;
    logic [7:0] slot_bytes [BUF_DEPTH];
    logic       dec_latched = 1'b0;
    logic [7:0] single_data = '0;
    logic       ce_pin      = 1'b0;
    logic       sclk_pin    = 1'b0;
    logic       io_pin      = 1'b0;
    result_t    pin_results_q [$];
    int         word_no     = 0;

    function automatic logic [7:0] bin_to_bcd(input logic [7:0] v);
        int n;
        n = (v > 8'd99) ? 99 : int'(v);
        return 8'(((n / 10) << 4) | (n % 10));
    endfunction

    function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
        return 8'(int'(v[7:4]) * 10 + int'(v[3:0]));
    endfunction

    function automatic logic [7:0] next_tx_byte(input logic [BYTE_CNT_W-1:0] k);
        if (xfer_kind == KIND_SWRITE) return single_data;
        if (!dec_latched) return slot_bytes[k[SLOT_W-1:0]];
        if (k == BYTE_CNT_W'(DEC_ZERO_POS)) return 8'h00;
        return bin_to_bcd(slot_bytes[k[SLOT_W-1:0]]);
    endfunction

    function automatic void close_byte();
        logic [BYTE_CNT_W-1:0] total;
        total = (xfer_kind == KIND_SWRITE || xfer_kind == KIND_SREAD)
                ? BYTE_CNT_W'(1) : BYTE_CNT_W'(BURST_BYTES);
        byte_idx    = byte_idx + BYTE_CNT_W'(1);
        bit_idx     = '0;
        second_half = 1'b0;
        if (byte_idx > total) begin
            bus_phase = BUS_STOP;
        end else if (xfer_kind == KIND_SWRITE || xfer_kind == KIND_BWRITE) begin
            shifter   = next_tx_byte(byte_idx - BYTE_CNT_W'(1));
            bus_phase = BUS_SEND;
        end else begin
            shifter   = '0;
            bus_phase = BUS_RECV;
        end
    endfunction

    function automatic result_t step_bus_levels(input item_t w);
        result_t r;
        r = '0;
        case (w.func)
            FUNC_LOAD: begin
                slot_bytes[w.reg_index] = w.write_value;
            end
            FUNC_SWRITE, FUNC_SREAD, FUNC_BWRITE, FUNC_BREAD: begin
                if (bus_phase == BUS_IDLE) begin
                    xfer_kind   = kind_t'(2'(w.func - 3'd1));
                    dec_latched = w.decimal_mode;
                    single_data = w.decimal_mode ? bin_to_bcd(w.write_value) : w.write_value;
                    case (xfer_kind)
                        KIND_SWRITE: shifter = CMD_WRITE | {4'd0, w.reg_index, 1'b0};
                        KIND_SREAD:  shifter = CMD_READ | {4'd0, w.reg_index, 1'b0};
                        KIND_BWRITE: shifter = CMD_BWRITE;
                        default:     shifter = CMD_BREAD;
                    endcase
                    bit_idx     = '0;
                    second_half = 1'b0;
                    byte_idx    = '0;
                    bus_phase   = BUS_SEND;
                    ce_pin      = 1'b1;
                    sclk_pin    = 1'b0;
                end
            end
            FUNC_TICK: begin
                case (bus_phase)
                    BUS_SEND: begin
                        if (!second_half) begin
                            io_pin      = shifter[bit_idx];
                            sclk_pin    = 1'b0;
                            second_half = 1'b1;
                        end else begin
                            sclk_pin    = 1'b1;
                            second_half = 1'b0;
                            if (bit_idx == 3'd7) close_byte();
                            else bit_idx = bit_idx + 3'd1;
                        end
                    end
                    BUS_RECV: begin
                        if (!second_half) begin
                            sclk_pin    = 1'b1;
                            second_half = 1'b1;
                        end else begin
                            sclk_pin    = 1'b0;
                            second_half = 1'b0;
                            if (w.io_sample) shifter[bit_idx] = 1'b1;
                            if (bit_idx == 3'd7) begin
                                r.read_value = dec_latched ? bcd_to_bin(shifter) : shifter;
                                r.read_slot  = 3'(byte_idx - BYTE_CNT_W'(1));
                                r.read_valid = 1'b1;
                                close_byte();
                            end else begin
                                bit_idx = bit_idx + 3'd1;
                            end
                        end
                    end
                    BUS_STOP: begin
                        ce_pin     = 1'b0;
                        sclk_pin   = 1'b0;
                        io_pin     = 1'b0;
                        bus_phase  = BUS_IDLE;
                        r.done_res = 1'b1;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.ce_level       = ce_pin;
        r.sclk_level     = sclk_pin;
        r.io_drive_level = io_pin;
        r.busy_res       = (bus_phase != BUS_IDLE);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        $display("mismatch at result word %0d, %s: got %0h, expected %0h",
                 word_no, what, got, want);
        fail_count++;
    endtask

    task automatic check_field(input string what, input logic [7:0] got, input logic [7:0] want);
        if (got !== want) report_mismatch(what, 24'(got), 24'(want));
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            bus_phase   = BUS_IDLE;
            xfer_kind   = KIND_SWRITE;
            bit_idx     = '0;
            second_half = 1'b0;
            byte_idx    = '0;
            shifter     = '0;
            dec_latched = 1'b0;
            single_data = '0;
            ce_pin      = 1'b0;
            sclk_pin    = 1'b0;
            io_pin      = 1'b0;
            pin_results_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[16:0]);
                if (pin_results_q.size() == 0) begin
                    report_mismatch("result word with nothing expected", m_tdata, '0);
                end else begin
                    want = pin_results_q.pop_front();
                    check_field("ce_level", 8'(got.ce_level), 8'(want.ce_level));
                    check_field("sclk_level", 8'(got.sclk_level), 8'(want.sclk_level));
                    check_field("io_drive_level", 8'(got.io_drive_level),
                                8'(want.io_drive_level));
                    check_field("read_value", got.read_value, want.read_value);
                    check_field("read_slot", 8'(got.read_slot), 8'(want.read_slot));
                    check_field("read_valid", 8'(got.read_valid), 8'(want.read_valid));
                    check_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
                    check_field("done_res", 8'(got.done_res), 8'(want.done_res));
                    check_field("padding", 8'(m_tdata[23:17]), 8'h00);
                end
                word_no++;
            end
            if (s_tvalid && s_tready)
                pin_results_q.push_back(step_bus_levels(item_t'({s_tdata[12:0], s_tuser})));
        end
        pending = pin_results_q.size();
    end

endmodule

// ===== tb/tb_three_wire_rtc_serial_master.sv =====
`timescale 1ns / 100ps

module tb_three_wire_rtc_serial_master;
    import rtc3w_pkg::*;

    localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
    localparam int RANDOM_WORDS = 1100;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int SINGLE_TICKS = 16 * 2 + 1;
    localparam int BURST_TICKS  = 16 * (BURST_BYTES + 1) + 1;
    localparam logic [7:0] PRESET_BYTES [BUF_DEPTH] = '{
        8'h00, 8'hFF, 8'd99, 8'd100, 8'h09, 8'h0A, 8'h5A, 8'hA5
    };

    typedef enum logic [1:0] {
        IO_RANDOM,
        IO_ONES,
        IO_ZEROS
    } io_mode_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    int fail_count;
    int pending;
    int pushed        = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles  = 0;
    bit press_on      = 1'b0;

    three_wire_rtc_serial_master u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    tb_rtc3w_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        @(posedge aresetn);
        while (quiet_cycles < STALL_LIMIT) @(posedge aclk);
        $display("FAILURE");
        $finish;
    end

    // hold off once for a long stretch so the block backs up
    initial begin
        bit held;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (press_on && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic push_word(input logic [2:0] f, input logic [2:0] idx, input logic [7:0] wv,
                             input logic dec, input logic smp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {3'b000, smp, dec, wv, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pushed++;
    endtask

    task automatic push_noise(input int lo);
        push_word(3'($urandom_range(7, lo)), 3'($urandom), 8'($urandom), 1'($urandom),
                  1'($urandom));
    endtask

    task automatic run_xfer(input logic [2:0] f, input logic [2:0] idx, input logic [7:0] wv,
                            input logic dec, input io_mode_t io_mode, input int noise_pct);
        int   n;
        logic smp;
        n = (f == FUNC_SWRITE || f == FUNC_SREAD) ? SINGLE_TICKS : BURST_TICKS;
        push_word(f, idx, wv, dec, 1'($urandom));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < noise_pct) push_noise(1);
            case (io_mode)
                IO_ONES:  smp = 1'b1;
                IO_ZEROS: smp = 1'b0;
                default:  smp = 1'($urandom);
            endcase
            push_word(FUNC_TICK, 3'($urandom), 8'($urandom), 1'($urandom), smp);
        end
    endtask

    initial begin
        int         rand_end;
        logic [2:0] f;
        logic [7:0] wv;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 13;
        recv_idle_pct = 76;

        // fill every burst slot before any burst write
        for (int i = 0; i < BUF_DEPTH; i++)
            push_word(FUNC_LOAD, 3'(i), PRESET_BYTES[i], 1'b0, 1'b0);
        push_word(FUNC_TICK, 3'd7, 8'hFF, 1'b1, 1'b1);
        push_word(FUNC_SPARE_LO, 3'd3, 8'h11, 1'b0, 1'b0);
        push_word(FUNC_SPARE_HI, 3'd4, 8'hEE, 1'b1, 1'b1);
        run_xfer(FUNC_SWRITE, 3'd0, 8'h00, 1'b0, IO_RANDOM, 0);
        run_xfer(FUNC_SWRITE, 3'd7, 8'hFF, 1'b1, IO_RANDOM, 0);
        run_xfer(FUNC_SREAD, 3'd7, 8'hFF, 1'b1, IO_ONES, 0);
        run_xfer(FUNC_SREAD, 3'd0, 8'h00, 1'b0, IO_ZEROS, 0);
        run_xfer(FUNC_BWRITE, 3'd0, 8'h00, 1'b1, IO_RANDOM, 4);
        run_xfer(FUNC_BWRITE, 3'd7, 8'hFF, 1'b0, IO_RANDOM, 0);
        run_xfer(FUNC_BREAD, 3'd0, 8'h00, 1'b1, IO_ONES, 0);
        run_xfer(FUNC_BREAD, 3'd5, 8'h80, 1'b0, IO_RANDOM, 4);

        rand_end = pushed + RANDOM_WORDS;
        while (pushed < rand_end) begin
            if (pushed >= rand_end - RANDOM_WORDS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                press_on      = 1'b1;
            end else if (pushed >= rand_end - 2 * RANDOM_WORDS / 3) begin
                send_idle_pct = 76;
                recv_idle_pct = 13;
            end
            if ($urandom_range(99) < 80) begin
                f  = 3'($urandom_range(FUNC_BREAD, FUNC_SWRITE));
                wv = $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(120));
                run_xfer(f, 3'($urandom), wv, 1'($urandom), IO_RANDOM, 3);
            end else begin
                repeat ($urandom_range(4, 1)) push_noise(0);
            end
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/rtc3w_pkg.sv
src/rtc3w_engine.sv
src/three_wire_rtc_serial_master.sv
tb/tb_rtc3w_checker.sv
tb/tb_three_wire_rtc_serial_master.sv
